// ----- hw/rtl/gdn_pkg.sv -----
// Package for the Gregorian day number converter.
// Holds the calendar constants, word types and the month length function.
// No dependencies.
package gdn_pkg;

  // Calendar range.
  localparam int BASE_YEAR = 1900;
  localparam int TOP_YEAR  = 9999;

  // Field widths.
  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int DNUM_W  = 22;
  localparam int ACC_W   = 23;

  // Days before January 1 of the base year, counted from January 1 of year 1.
  localparam int DAYS_BASE = 365 * (BASE_YEAR - 1) + (BASE_YEAR - 1) / 4
                             - (BASE_YEAR - 1) / 100 + (BASE_YEAR - 1) / 400;

  // Lengths of the Gregorian cycles in days.
  localparam int DAYS_400 = 146097;
  localparam int DAYS_100 = 36524;
  localparam int DAYS_4   = 1461;
  localparam int DAYS_1   = 365;

  // Commands.
  localparam logic CMD_TO_DAYS = 1'b0;
  localparam logic CMD_TO_DATE = 1'b1;

  // Month codes that the logic refers to.
  localparam logic [MONTH_W-1:0] MON_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MON_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MON_APR = 4'd4;
  localparam logic [MONTH_W-1:0] MON_JUN = 4'd6;
  localparam logic [MONTH_W-1:0] MON_SEP = 4'd9;
  localparam logic [MONTH_W-1:0] MON_NOV = 4'd11;
  localparam logic [MONTH_W-1:0] MON_DEC = 4'd12;

  // Input word.
  typedef struct packed {
    logic               command;
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic [DNUM_W-1:0]  day_number;
  } req_item_t;

  // Result word.
  typedef struct packed {
    logic [DNUM_W-1:0]  day_count;
    logic [YEAR_W-1:0]  out_year;
    logic [MONTH_W-1:0] out_month;
    logic [DAY_W-1:0]   out_day;
    logic               valid_res;
  } rsp_item_t;

  // Operands of the shared subtract and add unit.
  typedef struct packed {
    logic [ACC_W-1:0] rem;
    logic [ACC_W-1:0] sub;
    logic [ACC_W-1:0] sum;
    logic [ACC_W-1:0] add;
  } alu_op_t;

  // Results of the shared unit.
  typedef struct packed {
    logic             ge;
    logic [ACC_W-1:0] diff;
    logic [ACC_W-1:0] total;
  } alu_res_t;

  // Length of a month; codes outside 1 to 12 give 31 and are never used.
  function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
    logic [DAY_W-1:0] n;
    case (m)
      MON_FEB: n = leap ? 5'd29 : 5'd28;
      MON_APR, MON_JUN, MON_SEP, MON_NOV: n = 5'd30;
      default: n = 5'd31;
    endcase
    return n;
  endfunction

endpackage

// ----- hw/rtl/gdn_req_if.sv -----
// Request channel of the day number converter: valid, ready and one input word.
// Depends on gdn_pkg.
interface gdn_req_if;
  import gdn_pkg::*;

  logic      valid;
  logic      ready;
  req_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- hw/rtl/gdn_rsp_if.sv -----
// Response channel of the day number converter: valid, ready and one result word.
// Depends on gdn_pkg.
interface gdn_rsp_if;
  import gdn_pkg::*;

  logic      valid;
  logic      ready;
  rsp_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- hw/rtl/gregorian_day_number_converter_core.sv -----
// Gregorian date to day number converter, both directions.
// Steps from the accepted word to the result word: the shared subtract and add unit
// works through the 400, 100, 4 and 1 year steps, then up to 11 month steps; the
// number of steps grows with the year or day number and with the month.
// Throughput: one word at a time; the next word is taken the cycle after the result
// is loaded, and the finish step holds while the response register is full and not taken.
// Reset: rst, synchronous, clears the sequencer and the response valid.
module gregorian_day_number_converter_core (
  input logic     clk,
  input logic     rst,
  gdn_req_if.sink   req,
  gdn_rsp_if.source rsp
);
  import gdn_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_YEARS,
    ST_MONTHS,
    ST_FINISH
  } state_t;

  typedef enum logic [1:0] {
    PH_400,
    PH_100,
    PH_4,
    PH_1
  } phase_t;

  state_t             state;
  phase_t             phase;
  logic               cmd;
  logic [YEAR_W-1:0]  year_in;
  logic [MONTH_W-1:0] month_in;
  logic [DAY_W-1:0]   day_in;
  logic [ACC_W-1:0]   rem;
  logic [ACC_W-1:0]   sum;
  logic [4:0]         cnt;
  logic [1:0]         cent_cnt;
  logic [4:0]         quad_cnt;
  logic [1:0]         yr_cnt;
  logic [MONTH_W-1:0] mon;
  logic               out_valid;
  rsp_item_t          out_word;

  alu_op_t            alu_op;
  alu_res_t           alu_res;
  logic [ACC_W-1:0]   days_step;
  logic [ACC_W-1:0]   years_step;
  logic               capped;
  logic               year_take;
  logic               leap;
  logic [DAY_W-1:0]   mlen;
  logic               mon_take;
  logic               date_ok;
  logic [ACC_W-1:0]   days_full;
  logic [YEAR_W:0]    year_full;
  logic               out_free;
  rsp_item_t          result;

  gdn_alu u_alu (
    .op  (alu_op),
    .res (alu_res)
  );

  // Step sizes of each year phase, in days and in years.
  always_comb begin
    case (phase)
      PH_400: begin
        days_step  = ACC_W'(DAYS_400);
        years_step = ACC_W'(400);
      end
      PH_100: begin
        days_step  = ACC_W'(DAYS_100);
        years_step = ACC_W'(100);
      end
      PH_4: begin
        days_step  = ACC_W'(DAYS_4);
        years_step = ACC_W'(4);
      end
      default: begin
        days_step  = ACC_W'(DAYS_1);
        years_step = ACC_W'(1);
      end
    endcase
  end

  // The year is leap when it ends a four-year block; a century year only at the 400th year.
  assign leap = (yr_cnt == 2'd3) && ((quad_cnt != 5'd24) || (cent_cnt == 2'd3));
  assign mlen = month_days(mon, leap);

  // Operand selection for the shared unit. Date to days reduces years and adds
  // days; days to date reduces days and adds years.
  always_comb begin
    alu_op.rem = rem;
    alu_op.sum = sum;
    if (state == ST_MONTHS) begin
      alu_op.sub = ACC_W'(mlen);
      alu_op.add = ACC_W'(mlen);
    end else if (cmd == CMD_TO_DATE) begin
      alu_op.sub = days_step;
      alu_op.add = years_step;
    end else begin
      alu_op.sub = years_step;
      alu_op.add = days_step;
    end
  end

  // The century and single-year steps stop after three, so the last day of a
  // leap year stays in its own year.
  assign capped    = (phase == PH_100) || (phase == PH_1);
  assign year_take = alu_res.ge && !(capped && (cnt == 5'd3));

  // Month steps: date to days adds each month before the given one, days to
  // date removes whole months while they fit.
  always_comb begin
    if (cmd == CMD_TO_DATE) begin
      mon_take = (mon < MON_DEC) && alu_res.ge;
    end else begin
      mon_take = (mon < MON_DEC) && (mon < month_in);
    end
  end

  // Result assembly.
  always_comb begin
    date_ok = (32'(year_in) >= BASE_YEAR) && (32'(year_in) <= TOP_YEAR) &&
              (month_in >= MON_JAN) && (month_in <= MON_DEC) &&
              (day_in != '0) && (day_in <= month_days(month_in, leap));
    days_full = sum + ACC_W'(day_in) - ACC_W'(DAYS_BASE) - ACC_W'(1);
    year_full = sum[YEAR_W:0] + (YEAR_W+1)'(1);
    result    = '0;
    if (cmd == CMD_TO_DAYS) begin
      if (date_ok) begin
        result.day_count = days_full[DNUM_W-1:0];
        result.valid_res = 1'b1;
      end
    end else if (32'(year_full) <= TOP_YEAR) begin
      result.out_year  = year_full[YEAR_W-1:0];
      result.out_month = mon;
      result.out_day   = rem[DAY_W-1:0] + DAY_W'(1);
      result.valid_res = 1'b1;
    end
  end

  assign out_free  = !out_valid || rsp.ready;
  assign req.ready = (state == ST_IDLE);
  assign rsp.valid = out_valid;
  assign rsp.data  = out_word;

  // Sequencer, working registers and the response register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      phase     <= PH_400;
      out_valid <= 1'b0;
    end else begin
      // The response register fills from the finish step and empties when taken.
      if ((state == ST_FINISH) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (req.valid) begin
            cmd      <= req.data.command;
            year_in  <= req.data.year;
            month_in <= req.data.month;
            day_in   <= req.data.day;
            sum      <= '0;
            cnt      <= '0;
            phase    <= PH_400;
            if (req.data.command == CMD_TO_DATE) begin
              rem <= ACC_W'(req.data.day_number) + ACC_W'(DAYS_BASE);
            end else if (req.data.year == '0) begin
              rem <= '0;
            end else begin
              rem <= ACC_W'(req.data.year) - ACC_W'(1);
            end
            state <= ST_YEARS;
          end
        end
        ST_YEARS: begin
          if (year_take) begin
            rem <= alu_res.diff;
            sum <= alu_res.total;
            cnt <= cnt + 5'd1;
          end else begin
            cnt <= '0;
            case (phase)
              PH_400: phase <= PH_100;
              PH_100: begin
                cent_cnt <= cnt[1:0];
                phase    <= PH_4;
              end
              PH_4: begin
                quad_cnt <= cnt;
                phase    <= PH_1;
              end
              default: begin
                yr_cnt <= cnt[1:0];
                mon    <= MON_JAN;
                state  <= ST_MONTHS;
              end
            endcase
          end
        end
        ST_MONTHS: begin
          if (mon_take) begin
            if (cmd == CMD_TO_DATE) begin
              rem <= alu_res.diff;
            end else begin
              sum <= alu_res.total;
            end
            mon <= mon + MONTH_W'(1);
          end else begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            out_word <= result;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- hw/rtl/gdn_alu.sv -----
// Shared arithmetic unit of the day number converter: one compare and subtract
// and one add, used in every step of the sequencer. Depends on gdn_pkg.
module gdn_alu (
  input  gdn_pkg::alu_op_t  op,
  output gdn_pkg::alu_res_t res
);
  import gdn_pkg::*;

  // Compare the remainder against the step size, subtract it and accumulate.
  always_comb begin
    res.ge    = (op.rem >= op.sub);
    res.diff  = op.rem - op.sub;
    res.total = op.sum + op.add;
  end

endmodule
